// ----- rtl/gre_pkg.sv -----
// Shared types and constants for the Golomb-Rice escape encoder.
package gre_pkg;

  localparam int VALUE_W  = 32;
  localparam int K_W      = 5;
  localparam int LIMIT_W  = 10;
  localparam int CODE_W   = 32;
  localparam int COUNT_W  = 6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_RICE_K    = 1'b0;
  localparam logic REG_ESC_LIMIT = 1'b1;

  localparam logic [K_W-1:0]     RICE_K_RST    = 5'd2;
  localparam logic [LIMIT_W-1:0] ESC_LIMIT_RST = 10'd255;

  typedef struct packed {
    logic cap;
    logic prep;
    logic emit;
  } gre_cmd_t;

  typedef struct packed {
    logic last;
  } gre_sts_t;

endpackage

// ----- rtl/gre_ctrl.sv -----
// Sequencer for the encoder: capture, code setup and chunk output control.
module gre_ctrl
  import gre_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  gre_sts_t sts_i,
  output gre_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          // The final chunk frees the datapath, so the next item can enter now.
          if (sts_i.last) begin
            in_ready_o = 1'b1;
            if (in_valid_i) begin
              cmd_o.cap = 1'b1;
              state_d   = S_PREP;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_cap_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |=> (state_q == S_PREP))
    else $error("captured item did not move to setup");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted chunk not presented");

  a_prep_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |=> (state_q == S_EMIT))
    else $error("setup not followed by emit");
`endif

endmodule

// ----- rtl/gre_datapath.sv -----
// Datapath: zig-zag mapping, code construction and chunk extraction.
module gre_datapath
  import gre_pkg::*;
#(
  parameter int CHUNK_WIDTH = 32,
  parameter int ESCAPE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gre_cmd_t            cmd_i,
  output gre_sts_t            sts_o,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic                is_signed_i,
  input  logic [K_W-1:0]      rice_k_i,
  input  logic [LIMIT_W-1:0]  escape_limit_i,
  output logic [CODE_W-1:0]   code_bits_o,
  output logic [COUNT_W-1:0]  bit_count_o,
  output logic                last_o
);

  localparam int CW     = CHUNK_WIDTH;
  localparam int EB     = ESCAPE_BITS;
  localparam int KMAX   = (1 << K_W) - 1;
  localparam int TAIL_W = 1 + KMAX + EB;
  localparam int TW     = (TAIL_W > CW) ? TAIL_W : CW;
  localparam int TLW    = $clog2(TAIL_W + 1);
  localparam int SHW    = $clog2(TW);
  localparam int CNTW   = $clog2(CW + 1);
  localparam int RW     = LIMIT_W;
  localparam int SW     = ((RW > TLW) ? RW : TLW) + 1;
  localparam int MW     = (EB > VALUE_W) ? EB : VALUE_W;

  logic [VALUE_W-1:0] val_q;
  logic               sgn_q;
  logic [TW-1:0]      tail_q, tail_d;
  logic [TLW-1:0]     tl_q, tl_d;
  logic [RW-1:0]      r_q, r_d;
  logic [CW-1:0]      code_q;
  logic [CNTW-1:0]    count_q;
  logic               last_q;

  // Setup of one item's code.
  logic [VALUE_W-1:0] dbl, m;
  logic               esc;
  logic [LIMIT_W-1:0] c, qv, rem_mask, rem;
  logic [SHW-1:0]     sh_rem, sh_esc;
  logic [MW-1:0]      m_ext;
  logic [EB-1:0]      esc_field;
  logic [TW-1:0]      rem_left, esc_left;
  logic [TLW-1:0]     tl_new;

  assign dbl = {val_q[VALUE_W-2:0], 1'b0};

  always_comb begin
    if (sgn_q) begin
      // Negative words map to -2v+1, written as ~(2v) + 2.
      m = val_q[VALUE_W-1] ? (~dbl + VALUE_W'(2)) : dbl;
    end else begin
      m = val_q;
    end
  end

  assign esc       = (m >= VALUE_W'(escape_limit_i));
  assign c         = esc ? escape_limit_i : m[LIMIT_W-1:0];
  assign qv        = c >> rice_k_i;
  assign rem_mask  = ~({LIMIT_W{1'b1}} << rice_k_i);
  assign rem       = c & rem_mask;
  // The tail is stored left aligned: separator zero, remainder, escape word.
  assign sh_rem    = SHW'(TW - 1) - SHW'(rice_k_i);
  assign sh_esc    = sh_rem - SHW'(EB);
  assign m_ext     = MW'(m);
  assign esc_field = m_ext[EB-1:0];
  assign rem_left  = TW'(rem) << sh_rem;
  assign esc_left  = esc ? (TW'(esc_field) << sh_esc) : '0;
  assign tl_new    = TLW'(1) + TLW'(rice_k_i) + (esc ? TLW'(EB) : '0);

  // Chunk extraction: pending one-bits first, then the top of the tail.
  logic [SW-1:0]   rem_total;
  logic            last_chunk;
  logic [CNTW-1:0] n, r_eff, tuse;
  logic [CW-1:0]   ones_left, tail_top, chunk_left, aligned;

  assign rem_total  = SW'(r_q) + SW'(tl_q);
  assign last_chunk = (rem_total <= SW'(CW));
  assign n          = last_chunk ? CNTW'(rem_total) : CNTW'(CW);
  assign r_eff      = (SW'(r_q) < SW'(CW)) ? CNTW'(r_q) : CNTW'(CW);
  assign tuse       = n - r_eff;
  assign ones_left  = ~({CW{1'b1}} >> r_eff);
  assign tail_top   = tail_q[TW-1 -: CW];
  assign chunk_left = ones_left | (tail_top >> r_eff);
  assign aligned    = chunk_left >> (CNTW'(CW) - n);

  always_comb begin
    tail_d = tail_q;
    tl_d   = tl_q;
    r_d    = r_q;
    if (cmd_i.prep) begin
      tail_d = rem_left | esc_left;
      tl_d   = tl_new;
      r_d    = qv;
    end else if (cmd_i.emit) begin
      tail_d = tail_q << tuse;
      tl_d   = tl_q - TLW'(tuse);
      r_d    = r_q - RW'(r_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      val_q <= value_i;
      sgn_q <= is_signed_i;
    end
    tail_q <= tail_d;
    tl_q   <= tl_d;
    r_q    <= r_d;
    if (cmd_i.emit) begin
      code_q  <= aligned;
      count_q <= n;
      last_q  <= last_chunk;
    end
  end

  assign sts_o.last  = last_chunk;
  assign code_bits_o = CODE_W'(code_q);
  assign bit_count_o = COUNT_W'(count_q);
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  a_separator_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep |=> (tail_q[TW-1] == 1'b0))
    else $error("tail does not start with the separator bit");

  a_full_chunk_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !last_chunk) |=> (rem_total == $past(rem_total) - SW'(CW)))
    else $error("non-final chunk did not consume a full chunk");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q != '0))
    else $error("empty chunk emitted");
`endif

endmodule

// ----- rtl/golomb_rice_escape_encoder_core.sv -----
// An accepted item goes through setup, then emit, before its first chunk is presented.
// Each item takes one setup step, then one emit step per chunk;
// the chunk emitter produces one chunk per cycle while the output is taken.
// The next item is accepted in the cycle its predecessor's final chunk is emitted.
// Reset (rst_ni low, asynchronous) empties the output and restores rice_k = 2,
// escape_limit = 255.
module golomb_rice_escape_encoder_core
  import gre_pkg::*;
#(
  parameter int CHUNK_WIDTH = 32,
  parameter int ESCAPE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic                  is_signed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CODE_W-1:0]     code_bits_o,
  output logic [COUNT_W-1:0]    bit_count_o,
  output logic                  last_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [K_W-1:0]     rice_k_q;
  logic [LIMIT_W-1:0] escape_limit_q;
  logic               reg_idx;
  logic               wr_en;
  gre_cmd_t           cmd;
  gre_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rice_k_q       <= RICE_K_RST;
      escape_limit_q <= ESC_LIMIT_RST;
    end else if (wr_en) begin
      if (reg_idx == REG_RICE_K) begin
        rice_k_q <= pwdata[K_W-1:0];
      end else begin
        escape_limit_q <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RICE_K:    prdata = APB_DATA_W'(rice_k_q);
      REG_ESC_LIMIT: prdata = APB_DATA_W'(escape_limit_q);
      default:       prdata = '0;
    endcase
  end

  gre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gre_datapath #(
    .CHUNK_WIDTH (CHUNK_WIDTH),
    .ESCAPE_BITS (ESCAPE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .is_signed_i    (is_signed_i),
    .rice_k_i       (rice_k_q),
    .escape_limit_i (escape_limit_q),
    .code_bits_o    (code_bits_o),
    .bit_count_o    (bit_count_o),
    .last_o         (last_o)
  );

endmodule
